@@ rtl/core/sha1_stream_hash_unit_macros.svh @@
// Assertion macros for the SHA-1 stream hash unit.
`ifndef SHA1_STREAM_HASH_UNIT_MACROS_SVH
`define SHA1_STREAM_HASH_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on i_clk, off while reset is held.
`define SHU_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sha1 unit: same-cycle check failed");
// Next-cycle implication, sampled on i_clk, off while reset is held.
`define SHU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sha1 unit: next-cycle check failed");
`else
`define SHU_ASSERT_NOW(label, ante, cons)
`define SHU_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ rtl/core/sha1sh_pkg.sv @@
// Types and constants of the SHA-1 stream hash unit.
package sha1sh_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } t_sha1_in;

    typedef struct packed {
        logic [31:0] digest_word_a;
        logic [31:0] digest_word_b;
        logic [31:0] digest_word_c;
        logic [31:0] digest_word_d;
        logic [31:0] digest_word_e;
    } t_sha1_out;

    localparam logic [31:0] H_INIT0 = 32'h67452301;
    localparam logic [31:0] H_INIT1 = 32'hefcdab89;
    localparam logic [31:0] H_INIT2 = 32'h98badcfe;
    localparam logic [31:0] H_INIT3 = 32'h10325476;
    localparam logic [31:0] H_INIT4 = 32'hc3d2e1f0;

    localparam logic [31:0] K_PHASE0 = 32'h5a827999;
    localparam logic [31:0] K_PHASE1 = 32'h6ed9eba1;
    localparam logic [31:0] K_PHASE2 = 32'h8f1bbcdc;
    localparam logic [31:0] K_PHASE3 = 32'hca62c1d6;

    localparam logic [7:0] PAD_MARK = 8'h80;

    localparam logic [5:0] FILL_LAST = 6'd63;
    localparam logic [5:0] FILL_LEN  = 6'd56;
    localparam logic [6:0] ROUND_ADD = 7'd80;
    localparam logic [6:0] ROUND_P1  = 7'd20;
    localparam logic [6:0] ROUND_P2  = 7'd40;
    localparam logic [6:0] ROUND_P3  = 7'd60;

endpackage

@@ rtl/core/sha1_stream_hash_unit.sv @@
// SHA-1 stream hash unit: byte buffer, round sequencer, padding and digest output.
// Message bytes are taken one per cycle while idle; a full 64-byte block then runs
// 80 rounds on the shared round adder plus one chaining add, with the input stalled.
// End of message pushes one padding byte per cycle outside compression (9 to 72 bytes),
// compresses one or two blocks, then loads the digest register once no digest is held.
// Reset (synchronous, active low) restores the initial chaining words, clears the
// length and fill count, and clears the output valid flag.
`include "sha1_stream_hash_unit_macros.svh"

module sha1_stream_hash_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  sha1sh_pkg::t_sha1_in  i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output sha1sh_pkg::t_sha1_out o_out_data
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_COMP = 4'b0010,
        ST_PAD  = 4'b0100,
        ST_DONE = 4'b1000
    } t_state;

    typedef enum logic [1:0] {
        PH_MARK,
        PH_ZERO,
        PH_LEN
    } t_phase;

    t_state      r_state, n_state;
    t_phase      r_phase, n_phase;
    logic [5:0]  r_fill, n_fill;
    logic [6:0]  r_round, n_round;
    logic [63:0] r_bitlen, n_bitlen;
    logic [31:0] r_chain [5];
    logic [31:0] n_chain [5];
    logic [31:0] r_a, r_b, r_c, r_d, r_e;
    logic [31:0] n_a, n_b, n_c, n_d, n_e;
    logic [511:0] r_block, n_block;
    logic        r_final, n_final;
    logic        r_pad_pending, n_pad_pending;
    logic        r_out_valid, n_out_valid;
    sha1sh_pkg::t_sha1_out r_out_data, n_out_data;

    logic        push_en;
    logic [7:0]  push_byte;
    logic [31:0] w0, w2, w8, w13, w_new;
    logic [31:0] rf, rk, rtemp;

    // The block register doubles as the 16-word schedule window; word t sits on top.
    assign w0  = r_block[511:480];
    assign w2  = r_block[447:416];
    assign w8  = r_block[255:224];
    assign w13 = r_block[95:64];
    assign w_new = {w13[30:0] ^ w8[30:0] ^ w2[30:0] ^ w0[30:0],
                    w13[31] ^ w8[31] ^ w2[31] ^ w0[31]};

    always_comb begin
        priority if (r_round < sha1sh_pkg::ROUND_P1) begin
            rf = (r_b & r_c) | (~r_b & r_d);
            rk = sha1sh_pkg::K_PHASE0;
        end else if (r_round < sha1sh_pkg::ROUND_P2) begin
            rf = r_b ^ r_c ^ r_d;
            rk = sha1sh_pkg::K_PHASE1;
        end else if (r_round < sha1sh_pkg::ROUND_P3) begin
            rf = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            rk = sha1sh_pkg::K_PHASE2;
        end else begin
            rf = r_b ^ r_c ^ r_d;
            rk = sha1sh_pkg::K_PHASE3;
        end
        rtemp = {r_a[26:0], r_a[31:27]} + rf + r_e + rk + w0;
    end

    always_comb begin
        n_state       = r_state;
        n_phase       = r_phase;
        n_fill        = r_fill;
        n_round       = r_round;
        n_bitlen      = r_bitlen;
        n_chain       = r_chain;
        n_a           = r_a;
        n_b           = r_b;
        n_c           = r_c;
        n_d           = r_d;
        n_e           = r_e;
        n_block       = r_block;
        n_final       = r_final;
        n_pad_pending = r_pad_pending;
        n_out_valid   = r_out_valid & i_out_stall;
        n_out_data    = r_out_data;
        push_en       = 1'b0;
        push_byte     = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_data.byte_present) begin
                        push_en   = 1'b1;
                        push_byte = i_in_data.data_byte;
                        n_bitlen  = r_bitlen + 64'd8;
                    end
                    if (i_in_data.end_of_message) begin
                        n_state       = ST_PAD;
                        n_phase       = PH_MARK;
                        n_pad_pending = 1'b1;
                    end
                end
            end
            ST_PAD: begin
                push_en = 1'b1;
                unique case (r_phase)
                    PH_MARK: begin
                        push_byte = sha1sh_pkg::PAD_MARK;
                        n_phase   = PH_ZERO;
                    end
                    PH_ZERO: begin
                        if (r_fill == sha1sh_pkg::FILL_LEN) begin
                            push_byte = r_bitlen[63:56];
                            n_bitlen  = {r_bitlen[55:0], 8'h00};
                            n_phase   = PH_LEN;
                        end else begin
                            push_byte = 8'h00;
                        end
                    end
                    PH_LEN: begin
                        push_byte = r_bitlen[63:56];
                        n_bitlen  = {r_bitlen[55:0], 8'h00};
                        if (r_fill == sha1sh_pkg::FILL_LAST) begin
                            n_final = 1'b1;
                        end
                    end
                    default: begin
                        push_byte = 8'h00;
                        n_phase   = PH_MARK;
                    end
                endcase
            end
            ST_COMP: begin
                if (r_round == sha1sh_pkg::ROUND_ADD) begin
                    n_chain[0] = r_chain[0] + r_a;
                    n_chain[1] = r_chain[1] + r_b;
                    n_chain[2] = r_chain[2] + r_c;
                    n_chain[3] = r_chain[3] + r_d;
                    n_chain[4] = r_chain[4] + r_e;
                    priority if (r_final) begin
                        n_state = ST_DONE;
                    end else if (r_pad_pending) begin
                        n_state = ST_PAD;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end else begin
                    n_a     = rtemp;
                    n_b     = r_a;
                    n_c     = {r_b[1:0], r_b[31:2]};
                    n_d     = r_c;
                    n_e     = r_d;
                    n_block = {r_block[479:0], w_new};
                    n_round = r_round + 7'd1;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid              = 1'b1;
                    n_out_data.digest_word_a = r_chain[0];
                    n_out_data.digest_word_b = r_chain[1];
                    n_out_data.digest_word_c = r_chain[2];
                    n_out_data.digest_word_d = r_chain[3];
                    n_out_data.digest_word_e = r_chain[4];
                    n_chain[0]    = sha1sh_pkg::H_INIT0;
                    n_chain[1]    = sha1sh_pkg::H_INIT1;
                    n_chain[2]    = sha1sh_pkg::H_INIT2;
                    n_chain[3]    = sha1sh_pkg::H_INIT3;
                    n_chain[4]    = sha1sh_pkg::H_INIT4;
                    n_fill        = '0;
                    n_bitlen      = '0;
                    n_final       = 1'b0;
                    n_pad_pending = 1'b0;
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // A byte shifts into the block; the 64th byte of a block starts the rounds.
        if (push_en) begin
            n_block = {r_block[503:0], push_byte};
            n_fill  = r_fill + 6'd1;
            if (r_fill == sha1sh_pkg::FILL_LAST) begin
                n_state = ST_COMP;
                n_round = '0;
                n_a     = r_chain[0];
                n_b     = r_chain[1];
                n_c     = r_chain[2];
                n_d     = r_chain[3];
                n_e     = r_chain[4];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_phase       <= PH_MARK;
            r_fill        <= '0;
            r_round       <= '0;
            r_bitlen      <= '0;
            r_chain[0]    <= sha1sh_pkg::H_INIT0;
            r_chain[1]    <= sha1sh_pkg::H_INIT1;
            r_chain[2]    <= sha1sh_pkg::H_INIT2;
            r_chain[3]    <= sha1sh_pkg::H_INIT3;
            r_chain[4]    <= sha1sh_pkg::H_INIT4;
            r_final       <= 1'b0;
            r_pad_pending <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_phase       <= n_phase;
            r_fill        <= n_fill;
            r_round       <= n_round;
            r_bitlen      <= n_bitlen;
            r_chain       <= n_chain;
            r_final       <= n_final;
            r_pad_pending <= n_pad_pending;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a        <= n_a;
        r_b        <= n_b;
        r_c        <= n_c;
        r_d        <= n_d;
        r_e        <= n_e;
        r_block    <= n_block;
        r_out_data <= n_out_data;
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Rounds only start on a full block, so the fill count is back at zero throughout.
    `SHU_ASSERT_NOW(a_comp_fill_zero, r_state == ST_COMP, r_fill == 6'd0)
    `SHU_ASSERT_NOW(a_round_range, r_state == ST_COMP, r_round <= sha1sh_pkg::ROUND_ADD)
    // Length bytes go only into the last eight places of a block.
    `SHU_ASSERT_NOW(a_len_place, (r_state == ST_PAD) && (r_phase == PH_LEN),
                    r_fill >= sha1sh_pkg::FILL_LEN)
    // A finished digest waits while the previous one is still held.
    `SHU_ASSERT_NEXT(a_done_waits, (r_state == ST_DONE) && r_out_valid && i_out_stall,
                     r_state == ST_DONE)

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// Testbench for the SHA-1 stream hash unit: byte streams checked against a built-in SHA-1 model.
module tb;

    localparam int QUIET_LIMIT   = 5000;
    localparam int TAIL_CYCLES   = 400;
    localparam int ITEM_TARGET   = 1700;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    sha1sh_pkg::t_sha1_in  in_data   = '0;
    logic                  out_stall = 1'b0;
    logic                  in_stall;
    logic                  out_valid;
    sha1sh_pkg::t_sha1_out out_data;

    // Model of the hash state, advanced as each input beat is accepted.
    logic [31:0]           chain_h [5];
    logic [7:0]            blk_bytes [64];
    logic [5:0]            blk_fill;
    logic [63:0]           msg_bits;
    sha1sh_pkg::t_sha1_out digest_q [$];

    int  items_sent   = 0;
    int  digests_seen = 0;
    int  errors       = 0;
    int  quiet_cycles = 0;
    int  rx_hold      = 0;
    bit  tx_idle      = 1'b1;
    bit  rx_idle      = 1'b1;

    sha1_stream_hash_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic logic [31:0] rotl32(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic void restart_message();
        chain_h[0] = sha1sh_pkg::H_INIT0;
        chain_h[1] = sha1sh_pkg::H_INIT1;
        chain_h[2] = sha1sh_pkg::H_INIT2;
        chain_h[3] = sha1sh_pkg::H_INIT3;
        chain_h[4] = sha1sh_pkg::H_INIT4;
        blk_fill   = '0;
        msg_bits   = '0;
    endfunction

    function automatic void compress_block();
        logic [31:0] w [80];
        logic [31:0] a, b, c, d, e, f, k, t;
        for (int r = 0; r < 16; r++) begin
            w[r] = {blk_bytes[4*r], blk_bytes[4*r+1], blk_bytes[4*r+2], blk_bytes[4*r+3]};
        end
        for (int r = 16; r < 80; r++) begin
            w[r] = rotl32(w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16], 1);
        end
        a = chain_h[0];
        b = chain_h[1];
        c = chain_h[2];
        d = chain_h[3];
        e = chain_h[4];
        for (int r = 0; r < 80; r++) begin
            if (r < 20) begin
                f = (b & c) | (~b & d);
                k = sha1sh_pkg::K_PHASE0;
            end else if (r < 40) begin
                f = b ^ c ^ d;
                k = sha1sh_pkg::K_PHASE1;
            end else if (r < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = sha1sh_pkg::K_PHASE2;
            end else begin
                f = b ^ c ^ d;
                k = sha1sh_pkg::K_PHASE3;
            end
            t = rotl32(a, 5) + f + e + k + w[r];
            e = d;
            d = c;
            c = rotl32(b, 30);
            b = a;
            a = t;
        end
        chain_h[0] += a;
        chain_h[1] += b;
        chain_h[2] += c;
        chain_h[3] += d;
        chain_h[4] += e;
    endfunction

    function automatic void absorb_byte(input logic [7:0] v);
        blk_bytes[blk_fill] = v;
        blk_fill = blk_fill + 6'd1;
        if (blk_fill == 6'd0) begin
            compress_block();
        end
    endfunction

    // Applies one accepted beat; a finished message queues its digest.
    function automatic void hash_item(input sha1sh_pkg::t_sha1_in it);
        logic [63:0]           len;
        sha1sh_pkg::t_sha1_out dg;
        if (it.byte_present) begin
            absorb_byte(it.data_byte);
            msg_bits += 64'd8;
        end
        if (!it.end_of_message) begin
            return;
        end
        len = msg_bits;
        absorb_byte(sha1sh_pkg::PAD_MARK);
        while (blk_fill != sha1sh_pkg::FILL_LEN) begin
            absorb_byte(8'h00);
        end
        for (int i = 7; i >= 0; i--) begin
            absorb_byte(len[8*i +: 8]);
        end
        dg.digest_word_a = chain_h[0];
        dg.digest_word_b = chain_h[1];
        dg.digest_word_c = chain_h[2];
        dg.digest_word_d = chain_h[3];
        dg.digest_word_e = chain_h[4];
        digest_q.push_back(dg);
        restart_message();
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        errors++;
        $display("%0t: %s: got %h, expected %h", $realtime, what, got, want);
    endtask

    task automatic check_word(input string what, input logic [31:0] got,
                              input logic [31:0] want);
        if (got !== want) begin
            report_mismatch(what, got, want);
        end
    endtask

    task automatic send_item(input logic [7:0] data, input logic present, input logic eom);
        sha1sh_pkg::t_sha1_in it;
        int                   gap;
        it.data_byte      = data;
        it.byte_present   = present;
        it.end_of_message = eom;
        gap = tx_idle ? $urandom_range(11, 0) : 0;
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (in_stall !== 1'b0) @(posedge clk);
        hash_item(it);
        if (present || eom) begin
            items_sent++;
        end
    endtask

    // Holds the input off until every queued digest has come out.
    task automatic wait_for_digests();
        in_valid <= 1'b0;
        @(posedge clk);
        while (digest_q.size() != 0) @(posedge clk);
    endtask

    function automatic logic [7:0] random_byte();
        int pick;
        pick = $urandom_range(9, 0);
        if (pick == 0) begin
            return 8'h00;
        end else if (pick == 1) begin
            return 8'hff;
        end
        return 8'($urandom);
    endfunction

    // Lengths favor the padding and block boundaries: 55/56 decide whether the
    // length field still fits in the last block.
    function automatic int pick_length();
        int edges [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
        int pick;
        pick = $urandom_range(9, 0);
        if (pick < 5) begin
            return $urandom_range(20, 0);
        end else if (pick < 8) begin
            return edges[$urandom_range(9, 0)];
        end
        return $urandom_range(150, 0);
    endfunction

    task automatic send_message(input int len, input bit merge_end);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(99, 0) < 6) begin
                send_item(8'($urandom), 1'b0, 1'b0);
            end
            send_item(random_byte(), 1'b1, merge_end && (i == len - 1));
        end
        if (!merge_end || len == 0) begin
            send_item(8'($urandom), 1'b0, 1'b1);
        end
    endtask

    task automatic test_empty_message();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        // An empty beat must leave the state alone, whatever its data byte.
        send_item(8'h5a, 1'b0, 1'b0);
        send_item(8'ha5, 1'b0, 1'b1);
        send_item(8'h00, 1'b0, 1'b1);
    endtask

    task automatic test_short_messages();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hff, 1'b0, 1'b0);
        send_item(8'hff, 1'b1, 1'b0);
        send_item(8'hff, 1'b0, 1'b1);
        send_item(8'h80, 1'b1, 1'b1);
        send_item(8'hff, 1'b1, 1'b1);
        wait_for_digests();
    endtask

    task automatic test_random_messages();
        while (items_sent < ITEM_TARGET) begin
            tx_idle = ($urandom_range(9, 0) < 6);
            rx_idle = ($urandom_range(9, 0) < 6);
            send_message(pick_length(), 1'($urandom_range(1, 0)));
            if ($urandom_range(19, 0) == 0) begin
                wait_for_digests();
            end
        end
    endtask

    // Output side: compare each digest beat and draw the stall for the next one.
    always @(posedge clk) begin
        sha1sh_pkg::t_sha1_out want;
        if (!rst_n) begin
            rx_hold = 0;
            out_stall <= 1'b0;
        end else begin
            if (out_valid === 1'b1 && !out_stall) begin
                digests_seen++;
                if (digest_q.size() == 0) begin
                    report_mismatch("digest with none expected, word a",
                                    out_data.digest_word_a, 32'h0);
                end else begin
                    want = digest_q.pop_front();
                    check_word("digest word a", out_data.digest_word_a, want.digest_word_a);
                    check_word("digest word b", out_data.digest_word_b, want.digest_word_b);
                    check_word("digest word c", out_data.digest_word_c, want.digest_word_c);
                    check_word("digest word d", out_data.digest_word_d, want.digest_word_d);
                    check_word("digest word e", out_data.digest_word_e, want.digest_word_e);
                end
                rx_hold = rx_idle ? $urandom_range(11, 0) : 0;
            end else if (out_valid === 1'b1 && rx_hold != 0) begin
                rx_hold--;
            end
            out_stall <= (rx_hold != 0);
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[sha1_stream_hash_unit] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        restart_message();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        test_empty_message();
        test_short_messages();
        test_random_messages();
        wait_for_digests();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0) begin
            $display("[sha1_stream_hash_unit] OK");
        end else begin
            $display("[sha1_stream_hash_unit] ERROR");
        end
        $finish;
    end

endmodule
